// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers for the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: label");

`endif

// ===== hw/rtl/sdcrd_pkg.sv =====
// ----------------------------------------------------------------------------
// sdcrd_pkg
// types, tables and constants for the card register decoder
// ----------------------------------------------------------------------------
`default_nettype none

package sdcrd_pkg;

    localparam int unsigned UnitW   = 24;
    localparam int unsigned FactorW = 7;
    localparam int unsigned RateW   = 30;

    localparam logic [1:0] StructV2 = 2'd1;
    localparam logic [2:0] BusWide  = 3'd4;
    localparam logic [2:0] BusOne   = 3'd1;

    typedef struct packed {
        logic [31:0] csd_low_middle;
        logic [31:0] csd_high_middle;
        logic [31:0] csd_top;
        logic [31:0] scr_word;
    } sdcrd_in_t;

    typedef struct packed {
        logic [29:0] transfer_rate;
        logic [15:0] block_length;
        logic [32:0] block_count;
        logic [41:0] capacity_bytes;
        logic        layout_v2;
        logic [2:0]  bus_width_bits;
        logic [3:0]  spec_version;
    } sdcrd_out_t;

    // rate unit in tens of bits per second, reserved codes give zero
    function automatic logic [UnitW-1:0] rate_unit(input logic [2:0] code);
        logic [UnitW-1:0] val;
        case (code)
            3'd0:    val = 24'd10000;
            3'd1:    val = 24'd100000;
            3'd2:    val = 24'd1000000;
            3'd3:    val = 24'd10000000;
            default: val = '0;
        endcase
        return val;
    endfunction

    // time value factor, code zero keeps the unit as it is
    function automatic logic [FactorW-1:0] time_factor(input logic [3:0] code);
        logic [FactorW-1:0] val;
        case (code)
            4'd0:    val = 7'd1;
            4'd1:    val = 7'd10;
            4'd2:    val = 7'd12;
            4'd3:    val = 7'd13;
            4'd4:    val = 7'd15;
            4'd5:    val = 7'd20;
            4'd6:    val = 7'd25;
            4'd7:    val = 7'd30;
            4'd8:    val = 7'd35;
            4'd9:    val = 7'd40;
            4'd10:   val = 7'd45;
            4'd11:   val = 7'd50;
            4'd12:   val = 7'd55;
            4'd13:   val = 7'd60;
            4'd14:   val = 7'd70;
            default: val = 7'd80;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sd_card_register_decode.sv =====
// ----------------------------------------------------------------------------
// sd_card_register_decode
// decodes card-specific data and configuration words into card facts
// ----------------------------------------------------------------------------
//
// channel   ports                 transfer when
// -------   -------------------   -----------------------------
// command   start, busy, item     rising edge with start && !busy
// result    done, result          rising edge ending the done cycle
//
// one command transfer per cycle, back to back; busy is never raised
// each command passes input register, decode logic, result register
// the 24x7 rate multiply and the size shifts set the one path between them
// rst_n clears the two valid flags asynchronously, payload is not reset
// the receiver cannot stall: every result is shown for exactly one cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sd_card_register_decode (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    start,
    output logic                   busy,
    input  sdcrd_pkg::sdcrd_in_t   item,
    output logic                   done,
    output sdcrd_pkg::sdcrd_out_t  result
);

    // input stage
    logic                  in_valid_reg;
    logic                  in_valid_next;
    sdcrd_pkg::sdcrd_in_t  in_data_reg;

    // result stage
    logic                  out_valid_reg;
    logic                  out_valid_next;
    sdcrd_pkg::sdcrd_out_t out_data_reg;

    sdcrd_pkg::sdcrd_out_t facts;

    // a pure pipeline never holds off a command
    assign busy = 1'b0;

    assign in_valid_next  = start && !busy;
    assign out_valid_next = in_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // capture the words of each accepted transfer
    always_ff @(posedge clk)
    begin
        if (in_valid_next)
        begin
            in_data_reg <= item;
        end
    end

    sdcrd_decode u_decode (
        .words (in_data_reg),
        .facts (facts)
    );

    // register the decoded facts so the result port comes straight off flops
    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            out_data_reg <= facts;
        end
    end

    assign done   = out_valid_reg;
    assign result = out_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sdcrd_decode.sv =====
// ----------------------------------------------------------------------------
// sdcrd_decode
// combinational decode of one registered set of card register words
// ----------------------------------------------------------------------------
`default_nettype none

module sdcrd_decode (
    input  sdcrd_pkg::sdcrd_in_t  words,
    output sdcrd_pkg::sdcrd_out_t facts
);

    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] top;
    logic [31:0] scr;

    logic [sdcrd_pkg::UnitW-1:0]   unit;
    logic [sdcrd_pkg::FactorW-1:0] factor;
    logic [30:0] rate_full;

    logic [3:0]  blen_exp;
    logic        v2;

    logic [22:0] size_v2_plus1;
    logic [32:0] count_v2;
    logic [41:0] cap_v2;

    logic [12:0] size_v1_plus1;
    logic [2:0]  shamt_v1;
    logic [32:0] count_v1;
    logic [41:0] cap_v1;

    assign lo  = words.csd_low_middle;
    assign hi  = words.csd_high_middle;
    assign top = words.csd_top;
    assign scr = words.scr_word;

    // rate: unit table times time value factor
    assign unit      = sdcrd_pkg::rate_unit(top[2:0]);
    assign factor    = sdcrd_pkg::time_factor(top[6:3]);
    assign rate_full = {7'd0, unit} * {24'd0, factor};

    assign blen_exp = hi[19:16];
    assign v2       = (top[31:30] == sdcrd_pkg::StructV2);

    // high capacity layout: 22-bit size, units of 1024 blocks of 512 bytes
    assign size_v2_plus1 = {1'b0, hi[5:0], lo[31:16]} + 23'd1;
    assign count_v2      = {size_v2_plus1, 10'd0};
    assign cap_v2        = {size_v2_plus1, 19'd0};

    // standard layout: 12-bit size with multiplier
    assign size_v1_plus1 = {1'b0, hi[9:0], lo[31:30]} + 13'd1;
    assign shamt_v1      = {1'b0, lo[16:15]} + 3'd2;
    assign count_v1      = {20'd0, size_v1_plus1} << shamt_v1;
    assign cap_v1        = {9'd0, count_v1} << blen_exp;

    always_comb
    begin
        facts.transfer_rate  = rate_full[sdcrd_pkg::RateW-1:0];
        facts.block_length   = 16'd1 << blen_exp;
        facts.block_count    = v2 ? count_v2 : count_v1;
        facts.capacity_bytes = v2 ? cap_v2 : cap_v1;
        facts.layout_v2      = v2;
        facts.bus_width_bits = scr[18] ? sdcrd_pkg::BusWide : sdcrd_pkg::BusOne;
        facts.spec_version   = scr[27:24];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sdcrd_checker.sv =====
// ----------------------------------------------------------------------------
// sdcrd_checker
// port-level checks of the card register decoder, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sdcrd_checker (
    input wire                   clk,
    input wire                   rst_n,
    input wire                   start,
    input wire                   busy,
    input sdcrd_pkg::sdcrd_in_t  item,
    input wire                   done,
    input sdcrd_pkg::sdcrd_out_t result
);

    `ASSERT_NEVER(a_never_busy, clk, rst_n, busy)

    `ASSERT_IMPLIES(a_done_has_cmd, clk, rst_n, done, $past(start && !busy, 2))

    `ASSERT_IMPLIES(a_cmd_gives_done, clk, rst_n, $past(start && !busy, 2) && $past(rst_n, 2) && $past(rst_n, 1), done)

    `ASSERT_IMPLIES(a_layout_flag, clk, rst_n, done, result.layout_v2 == ($past(item.csd_top[31:30], 2) == sdcrd_pkg::StructV2))

    `ASSERT_IMPLIES(a_blen_onehot, clk, rst_n, done, $onehot(result.block_length))

endmodule

bind sd_card_register_decode sdcrd_checker u_sdcrd_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);

`default_nettype wire
